// File: sv/pbrs_pkg.sv
// ---------------------------------------------------------------------------
// pbrs_pkg
// Types, register indexes and reset values for the per-bin response smoother.
// ---------------------------------------------------------------------------
`default_nettype none

package pbrs_pkg;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_NO_MEAS_LEVEL = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENTER_THRESH  = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEAVE_THRESH  = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA         = 8'd3;

   localparam logic signed [15:0] RESET_NO_MEAS_LEVEL = -16'sd12800;
   localparam logic signed [15:0] RESET_ENTER_THRESH  = -16'sd3840;
   localparam logic signed [15:0] RESET_LEAVE_THRESH  = -16'sd4224;
   localparam logic        [15:0] RESET_ALPHA         = 16'd6554;

   typedef struct packed {
      logic        [9:0]  bin_index;
      logic signed [15:0] pre_left;
      logic signed [15:0] post_left;
      logic signed [15:0] pre_right;
      logic signed [15:0] post_right;
   } pbrs_req_type;

   typedef struct packed {
      logic        [9:0]  bin_out;
      logic signed [15:0] left_response;
      logic signed [15:0] right_response;
      logic signed [15:0] diff_response;
      logic               left_valid;
      logic               right_valid;
   } pbrs_rsp_type;

   // one RAM word per bin
   typedef struct packed {
      logic               left_gate;
      logic               right_gate;
      logic signed [15:0] left_smoothed;
      logic signed [15:0] right_smoothed;
      logic signed [15:0] diff_smoothed;
   } pbrs_entry_type;

   localparam pbrs_entry_type ENTRY_RESET = '{
      left_gate:      1'b0,
      right_gate:     1'b0,
      left_smoothed:  RESET_NO_MEAS_LEVEL,
      right_smoothed: RESET_NO_MEAS_LEVEL,
      diff_smoothed:  RESET_NO_MEAS_LEVEL
   };

   // pipeline register loads for one smoothing lane
   typedef struct packed {
      logic load_mid;
      logic load_last;
   } pbrs_lane_ctl_type;

   function automatic logic signed [15:0] pbrs_sat17(input logic signed [16:0] v);
      logic signed [15:0] r;
      if (v[16] != v[15]) begin
         r = v[16] ? 16'sh8000 : 16'sh7fff;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: sv/pbrs_ram.sv
// ---------------------------------------------------------------------------
// pbrs_ram
// Simple dual-port synchronous RAM, one write and one read port, registered
// read data that holds while no read is issued.
// ---------------------------------------------------------------------------
`default_nettype none

module pbrs_ram #(
   parameter int WIDTH = 50,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/pbrs_ema_lane.sv
// ---------------------------------------------------------------------------
// pbrs_ema_lane
// One sentinel-aware moving average lane: case select and difference, then
// alpha multiply, then shift, add and saturate.
// ---------------------------------------------------------------------------
`default_nettype none

module pbrs_ema_lane (
   input  wire logic                          clock,
   input  wire pbrs_pkg::pbrs_lane_ctl_type   ctl,
   input  wire logic signed [15:0]            sentinel,
   input  wire logic        [15:0]            alpha,
   input  wire logic signed [15:0]            prev,
   input  wire logic signed [15:0]            raw,
   output logic signed [15:0]                 smoothed
);

   typedef enum logic [1:0] {
      SEL_SENTINEL,
      SEL_SEED,
      SEL_AVERAGE
   } sel_type;

   logic signed [16:0] floor_lvl;
   logic signed [16:0] raw_ext;
   logic signed [16:0] prev_ext;
   logic signed [16:0] delta_in;
   sel_type            sel_in;

   sel_type            sel_mid_ff;
   logic signed [15:0] prev_mid_ff;
   logic signed [15:0] raw_mid_ff;
   logic signed [16:0] delta_mid_ff;

   logic signed [16:0] alpha_ext;
   logic signed [33:0] prod_in;

   sel_type            sel_last_ff;
   logic signed [15:0] prev_last_ff;
   logic signed [15:0] raw_last_ff;
   logic signed [33:0] prod_last_ff;

   logic signed [18:0] prev_wide;
   logic signed [18:0] step_wide;
   logic signed [18:0] sum_wide;
   logic signed [15:0] avg_sat;

   always_comb begin
      floor_lvl = {sentinel[15], sentinel} + 17'sd32;
      raw_ext   = {raw[15], raw};
      prev_ext  = {prev[15], prev};
      delta_in  = raw_ext - prev_ext;
      if (raw_ext <= floor_lvl) begin
         sel_in = SEL_SENTINEL;
      end else if (prev_ext <= floor_lvl) begin
         sel_in = SEL_SEED;
      end else begin
         sel_in = SEL_AVERAGE;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_mid) begin
         sel_mid_ff   <= sel_in;
         prev_mid_ff  <= prev;
         raw_mid_ff   <= raw;
         delta_mid_ff <= delta_in;
      end
   end

   assign alpha_ext = {1'b0, alpha};
   assign prod_in   = alpha_ext * delta_mid_ff;

   always_ff @(posedge clock) begin
      if (ctl.load_last) begin
         sel_last_ff  <= sel_mid_ff;
         prev_last_ff <= prev_mid_ff;
         raw_last_ff  <= raw_mid_ff;
         prod_last_ff <= prod_in;
      end
   end

   // floor shift of the product: take the top bits
   always_comb begin
      prev_wide = {{3{prev_last_ff[15]}}, prev_last_ff};
      step_wide = {prod_last_ff[33], prod_last_ff[33:16]};
      sum_wide  = prev_wide + step_wide;
      if (sum_wide > 19'sd32767) begin
         avg_sat = 16'sh7fff;
      end else if (sum_wide < -19'sd32768) begin
         avg_sat = 16'sh8000;
      end else begin
         avg_sat = sum_wide[15:0];
      end
      case (sel_last_ff)
         SEL_SENTINEL: smoothed = sentinel;
         SEL_SEED:     smoothed = raw_last_ff;
         SEL_AVERAGE:  smoothed = avg_sat;
         default:      smoothed = sentinel;
      endcase
   end

endmodule

`default_nettype wire

// File: sv/per_bin_response_smoother_core.sv
// ---------------------------------------------------------------------------
// per_bin_response_smoother_core
// Per-bin stereo response estimate: hysteresis gates and moving averages of
// post-minus-pre levels, kept in one RAM word per bin.
//
//   port group   dir  handshake            beat
//   req_*        in   req_valid/req_stall  pbrs_req_type
//   rsp_*        out  rsp_valid/rsp_stall  pbrs_rsp_type
//   csr_*        in   csr_valid/csr_ready  csr_index, csr_data
//
// One beat per cycle while no clearing pass, bin wait or rsp_stall holds it.
// A beat for a bin still held by one of the three stages after the RAM read
// waits until that write lands.
// After reset a clearing pass writes all NUM_BINS entries, one per cycle;
// req_stall is high during the pass. csr writes are taken anytime.
// rsp_stall fills the five stages, then raises req_stall.
// ---------------------------------------------------------------------------
`default_nettype none

module per_bin_response_smoother_core #(
   parameter int NUM_BINS = 1024
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,

   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire pbrs_pkg::pbrs_req_type                req_data,

   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output pbrs_pkg::pbrs_rsp_type                     rsp_data,

   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [pbrs_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [pbrs_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int AW      = $clog2(NUM_BINS);
   localparam int ENTRY_W = $bits(pbrs_pkg::pbrs_entry_type);

   // configuration
   logic signed [15:0] cfg_no_meas_ff;
   logic signed [15:0] cfg_enter_ff;
   logic signed [15:0] cfg_leave_ff;
   logic        [15:0] cfg_alpha_ff;

   // control
   logic          clearing_ff, clearing_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic          s1_v_ff, s1_v_in;
   logic          s2_v_ff, s2_v_in;
   logic          s3_v_ff, s3_v_in;
   logic          s4_v_ff, s4_v_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic req_accept, rsp_take;
   logic mv1, mv2, mv3, mv4;
   logic s1_free, s2_free, s3_free, s4_free;
   logic hazard;

   // stage 1: differences and threshold compares
   logic        [9:0]  s1_bin_ff;
   logic               s1_inr_ff;
   logic signed [15:0] s1_lsub_ff, s1_rsub_ff;
   logic               s1_lgt_ff, s1_llt_ff, s1_rgt_ff, s1_rlt_ff;
   logic signed [16:0] lsub_wide, rsub_wide, dsub_wide;
   logic               req_inr;

   // stage 2: RAM data available
   logic        [9:0]  s2_bin_ff;
   logic               s2_inr_ff;
   logic signed [15:0] s2_lsub_ff, s2_rsub_ff, s2_dsub_ff;
   logic               s2_lgt_ff, s2_llt_ff, s2_rgt_ff, s2_rlt_ff;
   pbrs_pkg::pbrs_entry_type rd_entry;
   logic               s2_lv, s2_rv;
   logic signed [15:0] l_raw, r_raw, d_raw;

   // stages 3 and 4
   logic [9:0] s3_bin_ff, s4_bin_ff;
   logic       s3_inr_ff, s4_inr_ff;
   logic       s3_lv_ff, s3_rv_ff, s4_lv_ff, s4_rv_ff;

   pbrs_pkg::pbrs_lane_ctl_type lane_ctl;
   logic signed [15:0] l_new, r_new, d_new;

   // RAM ports
   logic [ENTRY_W-1:0] rd_data;
   logic [AW-1:0]      rd_addr, s4_addr, wr_addr;
   logic [AW+9:0]      s1_bin_wide, s4_bin_wide;
   logic               wr_en;
   pbrs_pkg::pbrs_entry_type wr_entry;

   pbrs_pkg::pbrs_rsp_type rsp_data_ff, rsp_data_in;

   // -------------------------------------------------------------------------
   // configuration port
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_no_meas_ff <= pbrs_pkg::RESET_NO_MEAS_LEVEL;
         cfg_enter_ff   <= pbrs_pkg::RESET_ENTER_THRESH;
         cfg_leave_ff   <= pbrs_pkg::RESET_LEAVE_THRESH;
         cfg_alpha_ff   <= pbrs_pkg::RESET_ALPHA;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            pbrs_pkg::CSR_NO_MEAS_LEVEL: cfg_no_meas_ff <= csr_data;
            pbrs_pkg::CSR_ENTER_THRESH:  cfg_enter_ff   <= csr_data;
            pbrs_pkg::CSR_LEAVE_THRESH:  cfg_leave_ff   <= csr_data;
            pbrs_pkg::CSR_ALPHA:         cfg_alpha_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // flow control
   assign rsp_take = rsp_valid_ff && !rsp_stall;
   assign s4_free  = !s4_v_ff || !rsp_valid_ff || !rsp_stall;
   assign mv4      = s4_v_ff && s4_free;
   assign s3_free  = !s3_v_ff || s4_free;
   assign mv3      = s3_v_ff && s4_free;
   assign s2_free  = !s2_v_ff || s3_free;
   assign mv2      = s2_v_ff && s3_free;

   // same bin still in flight: wait for its write-back
   assign hazard = s1_inr_ff &&
                   ((s2_v_ff && s2_inr_ff && (s2_bin_ff == s1_bin_ff)) ||
                    (s3_v_ff && s3_inr_ff && (s3_bin_ff == s1_bin_ff)) ||
                    (s4_v_ff && s4_inr_ff && (s4_bin_ff == s1_bin_ff)));

   assign mv1        = s1_v_ff && s2_free && !hazard;
   assign s1_free    = !s1_v_ff || mv1;
   assign req_stall  = clearing_ff || !s1_free;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(NUM_BINS - 1)) begin
            clearing_in = 1'b0;
         end
      end
      s1_v_in      = req_accept ? 1'b1 : (mv1 ? 1'b0 : s1_v_ff);
      s2_v_in      = mv1 ? 1'b1 : (mv2 ? 1'b0 : s2_v_ff);
      s3_v_in      = mv2 ? 1'b1 : (mv3 ? 1'b0 : s3_v_ff);
      s4_v_in      = mv3 ? 1'b1 : (mv4 ? 1'b0 : s4_v_ff);
      rsp_valid_in = mv4 ? 1'b1 : (rsp_take ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         s4_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clearing_ff  <= clearing_in;
         clr_addr_ff  <= clr_addr_in;
         s1_v_ff      <= s1_v_in;
         s2_v_ff      <= s2_v_in;
         s3_v_ff      <= s3_v_in;
         s4_v_ff      <= s4_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // -------------------------------------------------------------------------
   // stage 1
   assign lsub_wide = {req_data.post_left[15], req_data.post_left} -
                      {req_data.pre_left[15], req_data.pre_left};
   assign rsub_wide = {req_data.post_right[15], req_data.post_right} -
                      {req_data.pre_right[15], req_data.pre_right};
   assign req_inr   = 32'(req_data.bin_index) < 32'(NUM_BINS);

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_bin_ff  <= req_data.bin_index;
         s1_inr_ff  <= req_inr;
         s1_lsub_ff <= pbrs_pkg::pbrs_sat17(lsub_wide);
         s1_rsub_ff <= pbrs_pkg::pbrs_sat17(rsub_wide);
         s1_lgt_ff  <= req_data.pre_left > cfg_enter_ff;
         s1_llt_ff  <= req_data.pre_left < cfg_leave_ff;
         s1_rgt_ff  <= req_data.pre_right > cfg_enter_ff;
         s1_rlt_ff  <= req_data.pre_right < cfg_leave_ff;
      end
   end

   assign dsub_wide   = {s1_rsub_ff[15], s1_rsub_ff} - {s1_lsub_ff[15], s1_lsub_ff};
   assign s1_bin_wide = {{AW{1'b0}}, s1_bin_ff};
   assign rd_addr     = s1_bin_wide[AW-1:0];

   always_ff @(posedge clock) begin
      if (mv1) begin
         s2_bin_ff  <= s1_bin_ff;
         s2_inr_ff  <= s1_inr_ff;
         s2_lsub_ff <= s1_lsub_ff;
         s2_rsub_ff <= s1_rsub_ff;
         s2_dsub_ff <= pbrs_pkg::pbrs_sat17(dsub_wide);
         s2_lgt_ff  <= s1_lgt_ff;
         s2_llt_ff  <= s1_llt_ff;
         s2_rgt_ff  <= s1_rgt_ff;
         s2_rlt_ff  <= s1_rlt_ff;
      end
   end

   // -------------------------------------------------------------------------
   // stage 2: gates and raw values
   assign rd_entry = rd_data;

   always_comb begin
      s2_lv = rd_entry.left_gate  ? !s2_llt_ff : s2_lgt_ff;
      s2_rv = rd_entry.right_gate ? !s2_rlt_ff : s2_rgt_ff;
      l_raw = s2_lv ? s2_lsub_ff : cfg_no_meas_ff;
      r_raw = s2_rv ? s2_rsub_ff : cfg_no_meas_ff;
      d_raw = (s2_lv && s2_rv) ? s2_dsub_ff : cfg_no_meas_ff;
   end

   always_ff @(posedge clock) begin
      if (mv2) begin
         s3_bin_ff <= s2_bin_ff;
         s3_inr_ff <= s2_inr_ff;
         s3_lv_ff  <= s2_lv;
         s3_rv_ff  <= s2_rv;
      end
      if (mv3) begin
         s4_bin_ff <= s3_bin_ff;
         s4_inr_ff <= s3_inr_ff;
         s4_lv_ff  <= s3_lv_ff;
         s4_rv_ff  <= s3_rv_ff;
      end
   end

   assign lane_ctl = '{load_mid: mv2, load_last: mv3};

   pbrs_ema_lane u_left_lane (
      .clock    (clock),
      .ctl      (lane_ctl),
      .sentinel (cfg_no_meas_ff),
      .alpha    (cfg_alpha_ff),
      .prev     (rd_entry.left_smoothed),
      .raw      (l_raw),
      .smoothed (l_new)
   );

   pbrs_ema_lane u_right_lane (
      .clock    (clock),
      .ctl      (lane_ctl),
      .sentinel (cfg_no_meas_ff),
      .alpha    (cfg_alpha_ff),
      .prev     (rd_entry.right_smoothed),
      .raw      (r_raw),
      .smoothed (r_new)
   );

   pbrs_ema_lane u_diff_lane (
      .clock    (clock),
      .ctl      (lane_ctl),
      .sentinel (cfg_no_meas_ff),
      .alpha    (cfg_alpha_ff),
      .prev     (rd_entry.diff_smoothed),
      .raw      (d_raw),
      .smoothed (d_new)
   );

   // -------------------------------------------------------------------------
   // stage 4: write-back and result
   assign s4_bin_wide = {{AW{1'b0}}, s4_bin_ff};
   assign s4_addr     = s4_bin_wide[AW-1:0];

   always_comb begin
      if (clearing_ff) begin
         wr_en    = 1'b1;
         wr_addr  = clr_addr_ff;
         wr_entry = pbrs_pkg::ENTRY_RESET;
      end else begin
         wr_en                   = mv4 && s4_inr_ff;
         wr_addr                 = s4_addr;
         wr_entry.left_gate      = s4_lv_ff;
         wr_entry.right_gate     = s4_rv_ff;
         wr_entry.left_smoothed  = l_new;
         wr_entry.right_smoothed = r_new;
         wr_entry.diff_smoothed  = d_new;
      end
   end

   pbrs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_BINS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (mv1),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_data_in.bin_out = s4_bin_ff;
      if (s4_inr_ff) begin
         rsp_data_in.left_response  = l_new;
         rsp_data_in.right_response = r_new;
         rsp_data_in.diff_response  = d_new;
         rsp_data_in.left_valid     = s4_lv_ff;
         rsp_data_in.right_valid    = s4_rv_ff;
      end else begin
         rsp_data_in.left_response  = cfg_no_meas_ff;
         rsp_data_in.right_response = cfg_no_meas_ff;
         rsp_data_in.diff_response  = cfg_no_meas_ff;
         rsp_data_in.left_valid     = 1'b0;
         rsp_data_in.right_valid    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mv4) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // -------------------------------------------------------------------------
   // checks
   a_no_accept_while_clearing: assert property (
      @(posedge clock) disable iff (reset)
      clearing_ff |-> !req_accept
   ) else $error("beat accepted during clearing pass");

   a_no_read_while_clearing: assert property (
      @(posedge clock) disable iff (reset)
      clearing_ff |-> !mv1
   ) else $error("state read during clearing pass");

   a_distinct_bins_s2_s3: assert property (
      @(posedge clock) disable iff (reset)
      (s2_v_ff && s3_v_ff && s2_inr_ff && s3_inr_ff) |-> (s2_bin_ff != s3_bin_ff)
   ) else $error("same bin in stages 2 and 3");

   a_distinct_bins_s2_s4: assert property (
      @(posedge clock) disable iff (reset)
      (s2_v_ff && s4_v_ff && s2_inr_ff && s4_inr_ff) |-> (s2_bin_ff != s4_bin_ff)
   ) else $error("same bin in stages 2 and 4");

   a_out_of_range_flags: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid_ff && (32'(rsp_data_ff.bin_out) >= 32'(NUM_BINS))) |->
         (!rsp_data_ff.left_valid && !rsp_data_ff.right_valid)
   ) else $error("gate flags set for bin beyond range");

endmodule

`default_nettype wire

// File: tb/per_bin_response_smoother_core_test.sv
// ---------------------------------------------------------------------------
// per_bin_response_smoother_core_test
// Drives level beats into the per-bin smoother and predicts each result from
// per-bin gate and moving-average state kept in the bench. Directed cases
// cover the hysteresis edges, raw saturation and the sentinel floor, followed
// by random beats over hot bins under several register settings, random
// stalls on both sides and one long output hold.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module per_bin_response_smoother_core_test;

   localparam int BIN_COUNT = 1024;
   localparam logic [pbrs_pkg::CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 8'ha5;

   class bin_response_tracker;
      int          no_meas;
      int          enter_lvl;
      int          leave_lvl;
      int unsigned alpha;
      bit          left_open  [BIN_COUNT];
      bit          right_open [BIN_COUNT];
      int          left_avg   [BIN_COUNT];
      int          right_avg  [BIN_COUNT];
      int          diff_avg   [BIN_COUNT];
      pbrs_pkg::pbrs_rsp_type pending_responses[$];
      int          mismatches;

      function new();
         no_meas    = pbrs_pkg::RESET_NO_MEAS_LEVEL;
         enter_lvl  = pbrs_pkg::RESET_ENTER_THRESH;
         leave_lvl  = pbrs_pkg::RESET_LEAVE_THRESH;
         alpha      = pbrs_pkg::RESET_ALPHA;
         mismatches = 0;
         for (int i = 0; i < BIN_COUNT; i++) begin
            left_open[i]  = 1'b0;
            right_open[i] = 1'b0;
            left_avg[i]   = pbrs_pkg::RESET_NO_MEAS_LEVEL;
            right_avg[i]  = pbrs_pkg::RESET_NO_MEAS_LEVEL;
            diff_avg[i]   = pbrs_pkg::RESET_NO_MEAS_LEVEL;
         end
      endfunction

      static function int clamp16(int v);
         if (v > 32767) return 32767;
         if (v < -32768) return -32768;
         return v;
      endfunction

      function void write_register(logic [pbrs_pkg::CSR_INDEX_W-1:0] idx, logic [15:0] val);
         case (idx)
            pbrs_pkg::CSR_NO_MEAS_LEVEL: no_meas = $signed(val);
            pbrs_pkg::CSR_ENTER_THRESH:  enter_lvl = $signed(val);
            pbrs_pkg::CSR_LEAVE_THRESH:  leave_lvl = $signed(val);
            pbrs_pkg::CSR_ALPHA:         alpha = val;
            default: ;
         endcase
      endfunction

      function bit gate_after(bit open, int pre);
         if (open) return !(pre < leave_lvl);
         return pre > enter_lvl;
      endfunction

      function int smooth(int prev, int raw);
         int     floor_lvl;
         longint prod;
         floor_lvl = no_meas + 32;
         if (raw <= floor_lvl) return no_meas;
         if (prev <= floor_lvl) return raw;
         prod = longint'(alpha) * longint'(raw - prev);
         return clamp16(prev + int'(prod >>> 16));
      endfunction

      function void note_request(pbrs_pkg::pbrs_req_type req);
         pbrs_pkg::pbrs_rsp_type want;
         int b, pre_l, post_l, pre_r, post_r, raw_l, raw_r, raw_d;
         bit lv, rv;
         b      = req.bin_index;
         pre_l  = $signed(req.pre_left);
         post_l = $signed(req.post_left);
         pre_r  = $signed(req.pre_right);
         post_r = $signed(req.post_right);
         lv = gate_after(left_open[b], pre_l);
         rv = gate_after(right_open[b], pre_r);
         left_open[b]  = lv;
         right_open[b] = rv;
         raw_l = lv ? clamp16(post_l - pre_l) : no_meas;
         raw_r = rv ? clamp16(post_r - pre_r) : no_meas;
         raw_d = (lv && rv) ? clamp16(raw_r - raw_l) : no_meas;
         left_avg[b]  = smooth(left_avg[b], raw_l);
         right_avg[b] = smooth(right_avg[b], raw_r);
         diff_avg[b]  = smooth(diff_avg[b], raw_d);
         want.bin_out        = req.bin_index;
         want.left_response  = 16'(left_avg[b]);
         want.right_response = 16'(right_avg[b]);
         want.diff_response  = 16'(diff_avg[b]);
         want.left_valid     = lv;
         want.right_valid    = rv;
         pending_responses.push_back(want);
      endfunction

      function void flag_error(string what, pbrs_pkg::pbrs_rsp_type want,
                               pbrs_pkg::pbrs_rsp_type got);
         mismatches++;
         if (mismatches <= 10)
            $display("%0t %s: expected bin %0d L %0d R %0d D %0d v %b%b, ",
                     $realtime, what, want.bin_out, want.left_response,
                     want.right_response, want.diff_response, want.left_valid,
                     want.right_valid,
                     "got bin %0d L %0d R %0d D %0d v %b%b",
                     got.bin_out, got.left_response,
                     got.right_response, got.diff_response, got.left_valid,
                     got.right_valid);
      endfunction

      function void check_response(pbrs_pkg::pbrs_rsp_type got);
         pbrs_pkg::pbrs_rsp_type want;
         if (pending_responses.size() == 0) begin
            flag_error("unexpected beat", '0, got);
            return;
         end
         want = pending_responses.pop_front();
         if (got.bin_out !== want.bin_out || got.left_response !== want.left_response
             || got.right_response !== want.right_response
             || got.diff_response !== want.diff_response
             || got.left_valid !== want.left_valid || got.right_valid !== want.right_valid)
            flag_error("mismatch", want, got);
      endfunction

      function int outstanding();
         return pending_responses.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   pbrs_pkg::pbrs_req_type req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   pbrs_pkg::pbrs_rsp_type rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [pbrs_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [pbrs_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   bin_response_tracker tracker = new();
   logic [9:0] hot_bins [6];
   bit  send_idle_enable = 1'b1;
   bit  rsp_idle_enable = 1'b1;
   bit  rsp_hold_asked = 1'b0;
   bit  rsp_hold_taken = 1'b0;
   int  rsp_hold_left = 0;

   per_bin_response_smoother_core #(
      .NUM_BINS(BIN_COUNT)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("per_bin_response_smoother_core_test: FAIL");
      $finish;
   end

   // result side: check accepted beats, then pick next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check_response(rsp_data);
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_stall <= 1'b1;
      end else if (rsp_hold_asked && !rsp_hold_taken) begin
         rsp_hold_taken = 1'b1;
         rsp_hold_left = 300;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= rsp_idle_enable && ($urandom_range(0, 99) < 26);
      end
   end

   function automatic logic [15:0] near_level(int center, int spread);
      int v;
      v = center + int'($urandom_range(0, 2 * spread)) - spread;
      return 16'(bin_response_tracker::clamp16(v));
   endfunction

   function automatic logic [15:0] pick_pre();
      case ($urandom_range(0, 9))
         0: return 16'($urandom_range(0, 65535));
         1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
         2, 3, 4, 5: return near_level(tracker.enter_lvl, 300);
         default: return near_level(tracker.leave_lvl, 300);
      endcase
   endfunction

   function automatic logic [15:0] pick_post(int pre);
      case ($urandom_range(0, 9))
         0: return 16'($urandom_range(0, 65535));
         1: return near_level(pre + ($urandom_range(0, 1) ? 40000 : -40000), 100);
         default: return near_level(pre, 3000);
      endcase
   endfunction

   function automatic pbrs_pkg::pbrs_req_type random_request();
      pbrs_pkg::pbrs_req_type item;
      if ($urandom_range(0, 9) < 7) item.bin_index = hot_bins[$urandom_range(0, 5)];
      else item.bin_index = 10'($urandom_range(0, BIN_COUNT - 1));
      item.pre_left   = pick_pre();
      item.post_left  = pick_post($signed(item.pre_left));
      item.pre_right  = pick_pre();
      item.post_right = pick_post($signed(item.pre_right));
      return item;
   endfunction

   task automatic send_request(input pbrs_pkg::pbrs_req_type item);
      while (send_idle_enable && $urandom_range(0, 99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      tracker.note_request(item);
   endtask

   task automatic send_levels(input int bin, input int pl, input int ql, input int pr,
                              input int qr);
      pbrs_pkg::pbrs_req_type item;
      item.bin_index  = 10'(bin);
      item.pre_left   = 16'(pl);
      item.post_left  = 16'(ql);
      item.pre_right  = 16'(pr);
      item.post_right = 16'(qr);
      send_request(item);
   endtask

   task automatic send_random(input int count);
      for (int i = 0; i < 6; i++) hot_bins[i] = 10'($urandom_range(0, BIN_COUNT - 1));
      repeat (count) send_request(random_request());
   endtask

   // drop valid and wait until every predicted result is back
   task automatic settle_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [pbrs_pkg::CSR_INDEX_W-1:0] idx, input int val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= 16'(val);
      do @(posedge clock); while (!csr_ready);
      tracker.write_register(idx, 16'(val));
   endtask

   task automatic program_registers(input int s, input int en, input int lv, input int a);
      write_csr(pbrs_pkg::CSR_NO_MEAS_LEVEL, s);
      write_csr(pbrs_pkg::CSR_ENTER_THRESH, en);
      write_csr(pbrs_pkg::CSR_LEAVE_THRESH, lv);
      write_csr(pbrs_pkg::CSR_ALPHA, a);
      write_csr(CSR_SPARE_INDEX, $urandom_range(0, 65535));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int e;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: gate edges, saturation, floor
      send_levels(0, -3840, 0, -32768, 32767);
      send_levels(0, -3839, -1000, -3839, -16607);
      send_levels(0, -4224, 0, -4224, -16991);
      send_levels(0, -4225, 0, 0, 32767);
      send_levels(0, -4000, 500, 0, 100);
      send_levels(0, -3000, 200, -4000, 300);
      send_levels(0, -4000, 900, -4100, 400);
      send_levels(1023, -3000, 32767, -3000, -32768);
      send_levels(1023, 0, -30000, 0, 30000);
      send_levels(1023, 32767, -32768, 32767, 32767);
      send_levels(512, -32768, -32768, 32767, 32767);
      send_levels(512, 0, 0, -4300, 0);
      for (int i = 0; i < 3; i++) begin
         send_levels(341, 1000 * i, 2000 - 700 * i, 500, 3000 * i);
         send_levels(682, -2000, -2000 + 1500 * i, 1000 * i, -5000);
      end
      send_random(250);
      settle_block();

      program_registers(-32768, -32768, -32768, 65535);
      send_random(250);
      settle_block();

      program_registers(32767, 32767, 32767, 0);
      send_random(200);
      settle_block();

      // sentinel moves without touching stored averages; no random gaps or stalls, then one long output hold
      program_registers(-6400, 0, -500, 32768);
      send_idle_enable = 1'b0;
      rsp_idle_enable <= 1'b0;
      send_random(250);
      rsp_hold_asked <= 1'b1;
      send_random(80);
      send_idle_enable = 1'b1;
      rsp_idle_enable <= 1'b1;
      settle_block();

      for (int k = 0; k < 3; k++) begin
         e = int'($urandom_range(0, 16000)) - 8000;
         if (k == 2)
            program_registers($urandom_range(0, 65535), $urandom_range(0, 65535),
                              $urandom_range(0, 65535), $urandom_range(0, 65535));
         else
            program_registers(int'($urandom_range(0, 24768)) - 32768, e,
                              e - int'($urandom_range(0, 1000)), $urandom_range(0, 65535));
         send_random(250);
         settle_block();
      end

      program_registers(pbrs_pkg::RESET_NO_MEAS_LEVEL, pbrs_pkg::RESET_ENTER_THRESH,
                        pbrs_pkg::RESET_LEAVE_THRESH, pbrs_pkg::RESET_ALPHA);
      send_random(170);
      settle_block();
      repeat (20) @(posedge clock);

      if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
         $display("per_bin_response_smoother_core_test: PASS");
      end else begin
         $display("per_bin_response_smoother_core_test: FAIL");
      end
      $finish;
   end

endmodule

// File: per_bin_response_smoother_core.f
sv/pbrs_pkg.sv
sv/pbrs_ram.sv
sv/pbrs_ema_lane.sv
sv/per_bin_response_smoother_core.sv
tb/per_bin_response_smoother_core_test.sv
